// ----- hw/rtl/qrs_pkg.sv -----
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared widths and root-count codes for the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

	localparam int COEF_W    = 16;   // coefficient width
	localparam int DISC_W    = 34;   // unsigned positive discriminant width
	localparam int DISC_PAIRS = DISC_W / 2;
	localparam int DEN_W     = 17;   // divisor magnitude width
	localparam int ROOT_W    = 40;   // output root width
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 88;

	typedef enum logic [1:0] {
		CNT_NONE = 2'd0,
		CNT_ONE  = 2'd1,
		CNT_TWO  = 2'd2,
		CNT_ANY  = 2'd3
	} count_t;

endpackage

// ----- hw/rtl/qrs_sqrt_pipe.sv -----
// ----------------------------------------------------------------------------
// qrs_sqrt_pipe
// Restoring square root, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
module qrs_sqrt_pipe
	import qrs_pkg::*;
#(
	parameter int STEPS = 33,
	parameter int SB_W  = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [DISC_W-1:0] in_d,
	input  logic [SB_W-1:0]   in_sb,
	output logic              out_valid,
	output logic [STEPS-1:0]  out_root,
	output logic [SB_W-1:0]   out_sb
);

	localparam int REM_W = STEPS + 2;

	logic              v_s   [0:STEPS];
	logic [DISC_W-1:0] d_s   [0:STEPS];
	logic [STEPS-1:0]  y_s   [0:STEPS];
	logic [REM_W-1:0]  rem_s [0:STEPS];
	logic [SB_W-1:0]   sb_s  [0:STEPS];

	assign v_s[0]   = in_valid;
	assign d_s[0]   = in_d;
	assign y_s[0]   = '0;
	assign rem_s[0] = '0;
	assign sb_s[0]  = in_sb;

	// one digit pair per stage; zeros shift in after the last pair
	for (genvar i = 0; i < STEPS; i++) begin : g_stage
		logic [REM_W-1:0] rem_sh;
		logic [REM_W-1:0] trial;
		logic             fits;

		assign rem_sh = {rem_s[i][REM_W-3:0], d_s[i][DISC_W-1 -: 2]};
		assign trial  = {y_s[i], 2'b01};
		assign fits   = (rem_sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d_s[i+1]   <= {d_s[i][DISC_W-3:0], 2'b00};
				rem_s[i+1] <= fits ? (rem_sh - trial) : rem_sh;
				y_s[i+1]   <= {y_s[i][STEPS-2:0], fits};
				sb_s[i+1]  <= sb_s[i];
			end
		end
	end

	assign out_valid = v_s[STEPS];
	assign out_root  = y_s[STEPS];
	assign out_sb    = sb_s[STEPS];

endmodule

// ----- hw/rtl/qrs_div_pipe.sv -----
// ----------------------------------------------------------------------------
// qrs_div_pipe
// Unsigned restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module qrs_div_pipe
	import qrs_pkg::*;
#(
	parameter int NUM_W = 34,
	parameter int SB_W  = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] in_num,
	input  logic [DEN_W-1:0] in_den,
	input  logic [SB_W-1:0]  in_sb,
	output logic             out_valid,
	output logic [NUM_W-1:0] out_quo,
	output logic [SB_W-1:0]  out_sb
);

	logic             v_s   [0:NUM_W];
	logic [NUM_W-1:0] n_s   [0:NUM_W];
	logic [DEN_W-1:0] den_s [0:NUM_W];
	logic [DEN_W-1:0] rem_s [0:NUM_W];
	logic [NUM_W-1:0] q_s   [0:NUM_W];
	logic [SB_W-1:0]  sb_s  [0:NUM_W];

	assign v_s[0]   = in_valid;
	assign n_s[0]   = in_num;
	assign den_s[0] = in_den;
	assign rem_s[0] = '0;
	assign q_s[0]   = '0;
	assign sb_s[0]  = in_sb;

	// shift in the next numerator bit, subtract when the divisor fits
	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic [DEN_W:0] rem_sh;
		logic [DEN_W:0] diff;
		logic           fits;

		assign rem_sh = {rem_s[i], n_s[i][NUM_W-1]};
		assign fits   = (rem_sh >= {1'b0, den_s[i]});
		assign diff   = rem_sh - {1'b0, den_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[i+1]   <= n_s[i] << 1;
				den_s[i+1] <= den_s[i];
				rem_s[i+1] <= fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
				q_s[i+1]   <= {q_s[i][NUM_W-2:0], fits};
				sb_s[i+1]  <= sb_s[i];
			end
		end
	end

	assign out_valid = v_s[NUM_W];
	assign out_quo   = q_s[NUM_W];
	assign out_sb    = sb_s[NUM_W];

endmodule

// ----- hw/rtl/quadratic_root_solver_top.sv -----
// ----------------------------------------------------------------------------
// quadratic_root_solver_top
// Real roots of a*x^2 + b*x + c = 0 in signed fixed point.
// ----------------------------------------------------------------------------
// Input stream s_*: tdata carries coef_a, coef_b, coef_c (signed 16 bits
// each). Output stream m_*: tdata carries root_count, root_first and
// root_second; roots are signed with FRAC_BITS fraction bits, truncated
// toward zero, and zero where the count does not cover them.
// A zero coef_a solves the linear equation instead (count 3 = any number).
// One coefficient set is taken per cycle unless stalled, one result for each.
// The pipeline runs through the product and discriminant registers,
// 17+FRAC_BITS square-root stages, a register forming numerators,
// 18+FRAC_BITS divider stages and the output register.
// Throughput is one transfer per cycle on each side when not stalled.
// Reset clears all valid bits; the pipeline comes up empty.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module quadratic_root_solver_top
	import qrs_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // coef_a, coef_b, coef_c
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata    // root_count, root_first, root_second
);

	localparam int STEPS = DISC_PAIRS + FRAC_BITS;
	localparam int NUM_W = FRAC_BITS + 18;   // numerator magnitude
	localparam int NW    = NUM_W + 1;        // signed numerator
	localparam int CW    = NUM_W + ROOT_W + 1;
	localparam int SQ_SB = 3 * COEF_W + 2;
	localparam int D1_SB = 3;
	localparam logic [CW-1:0] POS_MAX = CW'((64'd1 << (ROOT_W - 1)) - 64'd1);
	localparam logic [CW-1:0] NEG_MAX = CW'(64'd1 << (ROOT_W - 1));

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// stage 1: products
	logic                      v_s1;
	logic signed [COEF_W-1:0]  a_s1, b_s1, c_s1;
	logic signed [2*COEF_W-1:0] bb_s1, ac_s1;

	// stage 2: discriminant
	logic                      v_s2;
	logic signed [COEF_W-1:0]  a_s2, b_s2, c_s2;
	logic signed [DISC_W:0]    d_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= s_tdata[COEF_W-1:0];
			b_s1  <= s_tdata[2*COEF_W-1:COEF_W];
			c_s1  <= s_tdata[3*COEF_W-1:2*COEF_W];
			bb_s1 <= $signed(s_tdata[2*COEF_W-1:COEF_W]) * $signed(s_tdata[2*COEF_W-1:COEF_W]);
			ac_s1 <= $signed(s_tdata[COEF_W-1:0]) * $signed(s_tdata[3*COEF_W-1:2*COEF_W]);
			a_s2  <= a_s1;
			b_s2  <= b_s1;
			c_s2  <= c_s1;
			d_s2  <= $signed({{3{bb_s1[2*COEF_W-1]}}, bb_s1})
				- $signed({ac_s1[2*COEF_W-1], ac_s1, 2'b00});
		end
	end

	// square root of the positive discriminant
	logic              dpos, dzero;
	logic [DISC_W-1:0] d_in;
	assign dpos  = !d_s2[DISC_W] && (d_s2 != '0);
	assign dzero = (d_s2 == '0);
	assign d_in  = dpos ? d_s2[DISC_W-1:0] : '0;

	logic             sq_v;
	logic [STEPS-1:0] sq_root;
	logic [SQ_SB-1:0] sq_sb;

	qrs_sqrt_pipe #(.STEPS(STEPS), .SB_W(SQ_SB)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s2),
		.in_d     (d_in),
		.in_sb    ({dzero, dpos, c_s2, b_s2, a_s2}),
		.out_valid(sq_v),
		.out_root (sq_root),
		.out_sb   (sq_sb)
	);

	// stage 3: numerators, divisor, count
	logic [COEF_W-1:0] qa, qb, qc;
	logic              q_dpos, q_dzero, lin;
	assign qa      = sq_sb[COEF_W-1:0];
	assign qb      = sq_sb[2*COEF_W-1:COEF_W];
	assign qc      = sq_sb[3*COEF_W-1:2*COEF_W];
	assign q_dpos  = sq_sb[3*COEF_W];
	assign q_dzero = sq_sb[3*COEF_W+1];
	assign lin     = (qa == '0);

	logic signed [NW-1:0] bx, cx, sx, nb, num1, num2;
	logic signed [DEN_W:0] den;
	count_t cnt;

	always_comb begin
		bx   = $signed({{(NW-COEF_W){qb[COEF_W-1]}}, qb});
		cx   = $signed({{(NW-COEF_W){qc[COEF_W-1]}}, qc});
		sx   = $signed({2'b00, sq_root});
		nb   = (-bx) <<< FRAC_BITS;
		num1 = lin ? ((-cx) <<< FRAC_BITS) : (nb + sx);
		num2 = nb - sx;
		den  = lin ? $signed({{2{qb[COEF_W-1]}}, qb}) : $signed({qa[COEF_W-1], qa, 1'b0});
		if (lin) begin
			if (qb == '0) begin
				cnt = (qc == '0) ? CNT_ANY : CNT_NONE;
			end else begin
				cnt = CNT_ONE;
			end
		end else if (q_dpos) begin
			cnt = CNT_TWO;
		end else if (q_dzero) begin
			cnt = CNT_ONE;
		end else begin
			cnt = CNT_NONE;
		end
	end

	logic             v_s3;
	logic [NUM_W-1:0] n1_s3, n2_s3;
	logic [DEN_W-1:0] den_s3;
	logic             sg1_s3, sg2_s3;
	count_t           cnt_s3;

	logic [NW-1:0]    n1_abs, n2_abs;
	logic [DEN_W:0]   den_abs;
	assign n1_abs  = num1[NW-1] ? NW'(-num1) : NW'(num1);
	assign n2_abs  = num2[NW-1] ? NW'(-num2) : NW'(num2);
	assign den_abs = den[DEN_W] ? (DEN_W+1)'(-den) : (DEN_W+1)'(den);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n1_s3  <= n1_abs[NUM_W-1:0];
			n2_s3  <= n2_abs[NUM_W-1:0];
			den_s3 <= den_abs[DEN_W-1:0];
			sg1_s3 <= num1[NW-1] ^ den[DEN_W];
			sg2_s3 <= num2[NW-1] ^ den[DEN_W];
			cnt_s3 <= cnt;
		end
	end

	// two parallel dividers
	logic             dv1_v, dv2_v;
	logic [NUM_W-1:0] q1, q2;
	logic [D1_SB-1:0] d1_sb;
	logic             d2_sb;

	qrs_div_pipe #(.NUM_W(NUM_W), .SB_W(D1_SB)) u_div1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s3),
		.in_num   (n1_s3),
		.in_den   (den_s3),
		.in_sb    ({cnt_s3, sg1_s3}),
		.out_valid(dv1_v),
		.out_quo  (q1),
		.out_sb   (d1_sb)
	);

	qrs_div_pipe #(.NUM_W(NUM_W), .SB_W(1)) u_div2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s3),
		.in_num   (n2_s3),
		.in_den   (den_s3),
		.in_sb    (sg2_s3),
		.out_valid(dv2_v),
		.out_quo  (q2),
		.out_sb   (d2_sb)
	);

	// sign restore and saturation
	function automatic logic [ROOT_W-1:0] fix_root(input logic [NUM_W-1:0] mag,
			input logic neg);
		logic [CW-1:0]     m;
		logic [ROOT_W-1:0] r;
		m = CW'(mag);
		if (neg) begin
			r = (m > NEG_MAX) ? NEG_MAX[ROOT_W-1:0] : ROOT_W'(-m);
		end else begin
			r = (m > POS_MAX) ? POS_MAX[ROOT_W-1:0] : m[ROOT_W-1:0];
		end
		return r;
	endfunction

	count_t            ocnt;
	logic [ROOT_W-1:0] r1, r2;
	assign ocnt = count_t'(d1_sb[2:1]);
	assign r1 = (ocnt == CNT_ONE || ocnt == CNT_TWO) ? fix_root(q1, d1_sb[0]) : '0;
	assign r2 = (ocnt == CNT_TWO) ? fix_root(q2, d2_sb) : '0;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= dv1_v && dv2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {(OUT_DATA_W-2-2*ROOT_W)'(0), r2, r1, ocnt};
		end
	end

endmodule
